[src/avrlg_pkg.sv]
// Shared types, level codes and register indexes for the raster level generator.
package avrlg_pkg;

  localparam int unsigned ROW_W   = 10;
  localparam int unsigned BYTE_W  = 13;
  localparam int unsigned COL_W   = 12;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [LEVEL_W-1:0] LVL_BLACK = 7'd80;
  localparam logic [LEVEL_W-1:0] LVL_BLANK = 7'd85;
  localparam logic [LEVEL_W-1:0] LVL_SYNC  = 7'd100;

  localparam logic [ROW_W-1:0] FIRST_IMAGE_ROW = 10'd23;
  localparam logic [ROW_W-1:0] SYNC_ROWS       = 10'd2;
  localparam logic [COL_W-1:0] MIN_COLS        = 12'd16;
  localparam logic [COL_W-1:0] RESET_COLS      = 12'd512;

  // floor(c * 47 / 320) as (c * SYNC_W_MULT) >> SYNC_W_SHIFT, exact for 12-bit c
  localparam logic [21:0] SYNC_W_MULT  = 22'd2464154;
  localparam int unsigned SYNC_W_SHIFT = 24;

  // 75 times the Q16 luma weights; the level drop is the sum rounded up over 2^24
  localparam logic [30:0] LUMA_R     = 31'd1291200;
  localparam logic [30:0] LUMA_G     = 31'd3332475;
  localparam logic [30:0] LUMA_B     = 31'd291450;
  localparam logic [30:0] LUMA_ROUND = 31'd16777215;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR   = 3'd5;

  // Line timing derived from the column count
  typedef struct packed {
    logic [BYTE_W-1:0] row_len;
    logic [BYTE_W-1:0] blank_start;
    logic [BYTE_W-1:0] sync_start;
    logic [BYTE_W-1:0] sync_end;
    logic [COL_W-1:0]  vis_cols;
  } geom_t;

  // Overlay placement
  typedef struct packed {
    logic              mirror;
    logic [BYTE_W-1:0] offset_x;
    logic [ROW_W-1:0]  offset_y;
    logic [ROW_W-1:0]  rows_drawn;
    logic [COL_W-1:0]  cols_drawn;
  } ovl_t;

  // Per-position results handed to the pipeline
  typedef struct packed {
    logic               hit;
    logic [LEVEL_W-1:0] bg_level;
    logic               frame_start;
    logic               next_hit;
    logic [ROW_W-1:0]   next_row;
    logic [COL_W-1:0]   next_col;
  } pos_info_t;

  function automatic geom_t calc_geom(input logic [COL_W-1:0] cols);
    logic [COL_W-1:0] c;
    logic [13:0]      c3;
    logic [33:0]      wprod;
    geom_t            g;
    c     = (cols < MIN_COLS) ? MIN_COLS : cols;
    c3    = {2'b00, c} + {1'b0, c, 1'b0};
    wprod = 34'(c) * 34'(SYNC_W_MULT);
    g.row_len     = {c, 1'b0};
    g.blank_start = g.row_len - 13'(c3 >> 3);
    g.sync_start  = g.blank_start + 13'(c3 >> 6);
    g.sync_end    = g.sync_start + 13'(wprod >> SYNC_W_SHIFT);
    g.vis_cols    = c - 12'(c3 >> 4);
    return g;
  endfunction

endpackage

[src/avrlg_cfg.sv]
// Configuration registers and derived line timing and overlay placement.
module avrlg_cfg #(
  parameter int unsigned VISIBLE_ROWS = 576
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [avrlg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [avrlg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output avrlg_pkg::geom_t                   geom_o,
  output avrlg_pkg::ovl_t                    ovl_o
);

  avrlg_pkg::geom_t                 geom_q;
  logic [avrlg_pkg::COL_W-1:0]      width_q;
  logic [avrlg_pkg::ROW_W-1:0]      height_q;
  logic [avrlg_pkg::BYTE_W-1:0]     offset_x_q;
  logic [avrlg_pkg::ROW_W-1:0]      offset_y_q;
  logic                             mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q     <= avrlg_pkg::calc_geom(avrlg_pkg::RESET_COLS);
      width_q    <= '0;
      height_q   <= '0;
      offset_x_q <= '0;
      offset_y_q <= '0;
      mirror_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        avrlg_pkg::CFG_COLUMNS:  geom_q <= avrlg_pkg::calc_geom(cfg_wdata_i[11:0]);
        avrlg_pkg::CFG_WIDTH:    width_q <= cfg_wdata_i[11:0];
        avrlg_pkg::CFG_HEIGHT:   height_q <= cfg_wdata_i[9:0];
        avrlg_pkg::CFG_OFFSET_X: offset_x_q <= cfg_wdata_i;
        avrlg_pkg::CFG_OFFSET_Y: offset_y_q <= cfg_wdata_i[9:0];
        avrlg_pkg::CFG_MIRROR:   mirror_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  localparam logic [avrlg_pkg::ROW_W-1:0] VisRows = avrlg_pkg::ROW_W'(VISIBLE_ROWS);

  assign geom_o            = geom_q;
  assign ovl_o.mirror      = mirror_q;
  assign ovl_o.offset_x    = offset_x_q;
  assign ovl_o.offset_y    = offset_y_q;
  assign ovl_o.rows_drawn  = (height_q < VisRows) ? height_q : VisRows;
  assign ovl_o.cols_drawn  = (width_q < geom_q.vis_cols) ? width_q : geom_q.vis_cols;

endmodule

[src/avrlg_lookup.sv]
// Maps a raster position to a bitmap pixel, if the overlay covers it.
module avrlg_lookup #(
  parameter int unsigned VISIBLE_ROWS = 576
) (
  input  logic [avrlg_pkg::ROW_W-1:0]  row_i,
  input  logic [avrlg_pkg::BYTE_W-1:0] byte_i,
  input  avrlg_pkg::ovl_t              ovl_i,
  output logic                         hit_o,
  output logic [avrlg_pkg::ROW_W-1:0]  irow_o,
  output logic [avrlg_pkg::COL_W-1:0]  icol_o
);

  localparam logic [avrlg_pkg::ROW_W-1:0] VisRows = avrlg_pkg::ROW_W'(VISIBLE_ROWS);

  logic [avrlg_pkg::ROW_W-1:0]  k;
  logic [avrlg_pkg::ROW_W-1:0]  irow;
  logic [avrlg_pkg::BYTE_W-1:0] bx;
  logic [avrlg_pkg::COL_W-1:0]  col;
  logic                         row_ok;
  logic                         hit;

  always_comb begin
    k = row_i - avrlg_pkg::FIRST_IMAGE_ROW;
    if (ovl_i.mirror) begin
      row_ok = k < ovl_i.rows_drawn;
      irow   = ovl_i.rows_drawn - 10'd1 - k;
      bx     = byte_i;
    end else begin
      irow   = k - ovl_i.offset_y;
      row_ok = (k >= ovl_i.offset_y) && (k < VisRows) && (irow < ovl_i.rows_drawn)
               && (byte_i >= ovl_i.offset_x);
      bx     = byte_i - ovl_i.offset_x;
    end
    col = bx[avrlg_pkg::BYTE_W-1:1];
    hit = (row_i >= avrlg_pkg::FIRST_IMAGE_ROW) && row_ok && (col < ovl_i.cols_drawn);
  end

  assign hit_o  = hit;
  assign irow_o = hit ? irow : '0;
  assign icol_o = hit ? col : '0;

endmodule

[src/avrlg_raster.sv]
// Raster position counter with background level and overlay lookups.
module avrlg_raster #(
  parameter int unsigned TOTAL_ROWS   = 625,
  parameter int unsigned VISIBLE_ROWS = 576
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 restart_i,
  input  avrlg_pkg::geom_t     geom_i,
  input  avrlg_pkg::ovl_t      ovl_i,
  output avrlg_pkg::pos_info_t info_o
);

  localparam logic [avrlg_pkg::ROW_W-1:0] LastRow  = avrlg_pkg::ROW_W'(TOTAL_ROWS - 1);
  localparam logic [avrlg_pkg::ROW_W:0]   RowsWide = (avrlg_pkg::ROW_W + 1)'(TOTAL_ROWS);

  logic [avrlg_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic [avrlg_pkg::ROW_W-1:0]  row_q, row_d;
  logic [avrlg_pkg::LEVEL_W-1:0] bg;
  logic                         last_byte;
  logic                         cur_hit;
  logic [avrlg_pkg::ROW_W-1:0]  cur_irow;
  logic [avrlg_pkg::COL_W-1:0]  cur_icol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
      row_q  <= '0;
    end else if (restart_i) begin
      byte_q <= '0;
      row_q  <= '0;
    end else if (advance_i) begin
      byte_q <= byte_d;
      row_q  <= row_d;
    end
  end

  // Step to the next byte, wrap at row and frame end
  always_comb begin
    last_byte = byte_q == (geom_i.row_len - 13'd1);
    byte_d    = last_byte ? '0 : byte_q + 13'd1;
    if (!last_byte) begin
      row_d = row_q;
    end else if (row_q == LastRow) begin
      row_d = '0;
    end else begin
      row_d = row_q + 10'd1;
    end
  end

  always_comb begin
    bg = avrlg_pkg::LVL_BLACK;
    if (row_q < avrlg_pkg::FIRST_IMAGE_ROW || ({1'b0, row_q} + 11'd2) >= RowsWide) begin
      bg = avrlg_pkg::LVL_BLANK;
    end
    if (row_q < avrlg_pkg::SYNC_ROWS) begin
      bg = avrlg_pkg::LVL_SYNC;
    end
    if (byte_q >= geom_i.blank_start) begin
      bg = avrlg_pkg::LVL_BLANK;
      if (byte_q >= geom_i.sync_start && byte_q < geom_i.sync_end) begin
        bg = avrlg_pkg::LVL_SYNC;
      end
    end
  end

  avrlg_lookup #(.VISIBLE_ROWS(VISIBLE_ROWS)) u_lookup_cur (
    .row_i  (row_q),
    .byte_i (byte_q),
    .ovl_i  (ovl_i),
    .hit_o  (cur_hit),
    .irow_o (cur_irow),
    .icol_o (cur_icol)
  );

  avrlg_lookup #(.VISIBLE_ROWS(VISIBLE_ROWS)) u_lookup_next (
    .row_i  (row_d),
    .byte_i (byte_d),
    .ovl_i  (ovl_i),
    .hit_o  (info_o.next_hit),
    .irow_o (info_o.next_row),
    .icol_o (info_o.next_col)
  );

  // Only the hit flag of the current position matters; its pixel arrives on the inputs
  assign info_o.hit         = cur_hit & (|{cur_irow, cur_icol} | 1'b1);
  assign info_o.bg_level    = bg;
  assign info_o.frame_start = (row_q == '0) && (byte_q == '0);

endmodule

[src/avrlg_luma.sv]
// Converts an RGB pixel to an overlay amplitude level.
module avrlg_luma (
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  output logic [avrlg_pkg::LEVEL_W-1:0] level_o
);

  logic [30:0] sum;

  // 80 - ceil(75 * Y * 2^24 / 2^24), with the factor 75 folded into the weights
  always_comb begin
    sum = 31'(red_i) * avrlg_pkg::LUMA_R + 31'(green_i) * avrlg_pkg::LUMA_G
        + 31'(blue_i) * avrlg_pkg::LUMA_B + avrlg_pkg::LUMA_ROUND;
    level_o = avrlg_pkg::LVL_BLACK - sum[30:24];
  end

endmodule

[src/analog_video_raster_level_generator_core.sv]
// Top level of the composite video raster level generator.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_ready_o  red_i, green_i, blue_i
//   output   out        out_valid_o/out_ready_i  level_o, next_in_image_o,
//                                                next_image_row_o, next_image_col_o,
//                                                frame_start_o
//   config   in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One beat per clock while the output is not stalled; each beat goes through both stages.
// Stage one latches the pixel with the position's background level and overlay
// hit; stage two runs the constant-weight luma sum and holds the result.
// Reset puts the raster at row 0, byte 0 and the config registers at their defaults;
// a column count write restarts the frame at row 0, byte 0.
// A stall on the output holds both stages; input ready drops only when both are full.
module analog_video_raster_level_generator_core #(
  parameter int unsigned TOTAL_ROWS   = 625,
  parameter int unsigned VISIBLE_ROWS = 576
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          red_i,
  input  logic [7:0]                          green_i,
  input  logic [7:0]                          blue_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [avrlg_pkg::LEVEL_W-1:0]       level_o,
  output logic                                next_in_image_o,
  output logic [avrlg_pkg::ROW_W-1:0]         next_image_row_o,
  output logic [avrlg_pkg::COL_W-1:0]         next_image_col_o,
  output logic                                frame_start_o,
  input  logic                                cfg_we_i,
  input  logic [avrlg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [avrlg_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  avrlg_pkg::geom_t     geom;
  avrlg_pkg::ovl_t      ovl;
  avrlg_pkg::pos_info_t info;

  logic in_accept;
  logic s1_ready;
  logic out_free;
  logic restart;

  // Stage one: latched pixel and position results
  logic                         s1_valid_q;
  logic [7:0]                   red_q, green_q, blue_q;
  avrlg_pkg::pos_info_t         s1_info_q;

  // Stage two: result register
  logic                          out_valid_q;
  logic [avrlg_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [avrlg_pkg::LEVEL_W-1:0] luma;
  logic                          next_in_image_q;
  logic [avrlg_pkg::ROW_W-1:0]   next_row_q;
  logic [avrlg_pkg::COL_W-1:0]   next_col_q;
  logic                          frame_start_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_free;
  assign in_ready_o = s1_ready;
  assign in_accept  = in_valid_i && s1_ready;
  assign restart    = cfg_we_i && (cfg_idx_i == avrlg_pkg::CFG_COLUMNS);

  avrlg_cfg #(.VISIBLE_ROWS(VISIBLE_ROWS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom),
    .ovl_o       (ovl)
  );

  avrlg_raster #(
    .TOTAL_ROWS   (TOTAL_ROWS),
    .VISIBLE_ROWS (VISIBLE_ROWS)
  ) u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_accept),
    .restart_i (restart),
    .geom_i    (geom),
    .ovl_i     (ovl),
    .info_o    (info)
  );

  avrlg_luma u_luma (
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .level_o (luma)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage one payload: capture on each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      red_q     <= red_i;
      green_q   <= green_i;
      blue_q    <= blue_i;
      s1_info_q <= info;
    end
  end

  // Overlay pixels take the luma level, everything else the background
  assign level_d = s1_info_q.hit ? luma : s1_info_q.bg_level;

  // Stage two payload: advance when the output slot is free
  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      level_q         <= level_d;
      next_in_image_q <= s1_info_q.next_hit;
      next_row_q      <= s1_info_q.next_row;
      next_col_q      <= s1_info_q.next_col;
      frame_start_q   <= s1_info_q.frame_start;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign level_o          = level_q;
  assign next_in_image_o  = next_in_image_q;
  assign next_image_row_o = next_row_q;
  assign next_image_col_o = next_col_q;
  assign frame_start_o    = frame_start_q;

endmodule

[sim/testbench.sv]
// Self-checking bench for the raster level generator: pixel beats, predictor, checker.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TOTAL_ROWS     = 625;
  localparam int unsigned VISIBLE_ROWS   = 576;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 250;
  localparam int unsigned HOLD_AT_BEAT   = 900;
  localparam logic [avrlg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  // Q16 luma weights, applied over 2^24 after the 75x level span
  localparam longint unsigned WEIGHT_R   = 17216;
  localparam longint unsigned WEIGHT_G   = 44433;
  localparam longint unsigned WEIGHT_B   = 3886;
  localparam longint unsigned LEVEL_SPAN = 75;
  localparam longint unsigned ROUND_UP   = 16777215;

  typedef logic [avrlg_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [avrlg_pkg::LEVEL_W-1:0] level;
    logic                          in_img;
    logic [avrlg_pkg::ROW_W-1:0]   img_row;
    logic [avrlg_pkg::COL_W-1:0]   img_col;
    logic                          fstart;
  } level_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       red = 8'h00;
  logic [7:0]                       green = 8'h00;
  logic [7:0]                       blue = 8'h00;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [avrlg_pkg::LEVEL_W-1:0]    level;
  logic                             next_in_image;
  logic [avrlg_pkg::ROW_W-1:0]      next_image_row;
  logic [avrlg_pkg::COL_W-1:0]      next_image_col;
  logic                             frame_start;
  logic                             cfg_we = 1'b0;
  logic [avrlg_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  cfg_word_t                        cfg_wdata = '0;

  // Pixels waiting to be offered, and levels the block owes us, oldest first
  pixel_t      pixel_feed_q[$];
  level_beat_t level_due_q[$];

  // Predictor copy of the registers and the scan position
  logic [avrlg_pkg::COL_W-1:0]  ras_cols;
  logic [avrlg_pkg::COL_W-1:0]  ras_img_w;
  logic [avrlg_pkg::ROW_W-1:0]  ras_img_h;
  logic [avrlg_pkg::BYTE_W-1:0] ras_off_x;
  logic [avrlg_pkg::ROW_W-1:0]  ras_off_y;
  logic                         ras_mirror;
  logic [avrlg_pkg::BYTE_W-1:0] ras_byte;
  logic [avrlg_pkg::ROW_W-1:0]  ras_row;

  int unsigned gap_odds = 0;   // percent chance per cycle to start an idle burst
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned beats_out = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  pixel_t      next_px;
  pixel_t      beat_px;
  level_beat_t got_beat;
  level_beat_t want_beat;

  analog_video_raster_level_generator_core #(
    .TOTAL_ROWS  (TOTAL_ROWS),
    .VISIBLE_ROWS(VISIBLE_ROWS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .level_o         (level),
    .next_in_image_o (next_in_image),
    .next_image_row_o(next_image_row),
    .next_image_col_o(next_image_col),
    .frame_start_o   (frame_start),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Raster predictor
  // ---------------------------------------------------------------------------

  // Column counts below the minimum behave as the minimum
  function automatic int unsigned active_cols();
    return (ras_cols < avrlg_pkg::MIN_COLS) ? int'(avrlg_pkg::MIN_COLS) : int'(ras_cols);
  endfunction

  function automatic int unsigned line_bytes();
    return 2 * active_cols();
  endfunction

  // Level of the frame with no bitmap on it
  function automatic logic [avrlg_pkg::LEVEL_W-1:0] backdrop_level(int unsigned row,
                                                                   int unsigned b);
    int unsigned len;
    int unsigned tail_start;
    int unsigned sync_off;
    int unsigned sync_len;
    logic [avrlg_pkg::LEVEL_W-1:0] lvl;
    len        = line_bytes();
    tail_start = len - (len * 120) / 640;
    sync_off   = (len * 15) / 640;
    sync_len   = (len * 47) / 640;
    lvl        = avrlg_pkg::LVL_BLACK;
    if (row < avrlg_pkg::FIRST_IMAGE_ROW || row + 2 >= TOTAL_ROWS) lvl = avrlg_pkg::LVL_BLANK;
    if (row < avrlg_pkg::SYNC_ROWS) lvl = avrlg_pkg::LVL_SYNC;
    // Horizontal blanking tail, with the line sync pulse inside it
    if (b >= tail_start) begin
      lvl = avrlg_pkg::LVL_BLANK;
      if (b >= tail_start + sync_off && b < tail_start + sync_off + sync_len)
        lvl = avrlg_pkg::LVL_SYNC;
    end
    return lvl;
  endfunction

  // Map a frame position to a bitmap pixel; 0 when the position is not drawn
  function automatic bit overlay_pixel(input int unsigned row, input int unsigned b,
                                       output int unsigned irow, output int unsigned icol);
    int unsigned c;
    int unsigned rows_dr;
    int unsigned cols_dr;
    int unsigned k;
    int unsigned bx;
    irow    = 0;
    icol    = 0;
    c       = active_cols();
    rows_dr = (ras_img_h < VISIBLE_ROWS) ? int'(ras_img_h) : VISIBLE_ROWS;
    cols_dr = (ras_img_w < c - (c * 120) / 640) ? int'(ras_img_w) : c - (c * 120) / 640;
    if (b >= line_bytes() || row < avrlg_pkg::FIRST_IMAGE_ROW) return 1'b0;
    k = row - avrlg_pkg::FIRST_IMAGE_ROW;
    if (ras_mirror) begin
      // Upside down, pinned to the first image row and byte 0
      if (k >= rows_dr) return 1'b0;
      irow = rows_dr - 1 - k;
      bx   = b;
    end else begin
      // Bitmap rows pushed past the visible area are never drawn
      if (k < ras_off_y || k >= VISIBLE_ROWS) return 1'b0;
      irow = k - ras_off_y;
      if (irow >= rows_dr || b < ras_off_x) return 1'b0;
      bx = b - ras_off_x;
    end
    icol = bx / 2;
    if (icol >= cols_dr) return 1'b0;
    return 1'b1;
  endfunction

  // 80 minus the luma, rounded so that white lands on 5
  function automatic logic [avrlg_pkg::LEVEL_W-1:0] luma_level(pixel_t px);
    longint unsigned sum;
    longint unsigned drop;
    sum  = WEIGHT_R * 64'(px.red) + WEIGHT_G * 64'(px.green) + WEIGHT_B * 64'(px.blue);
    drop = (LEVEL_SPAN * sum + ROUND_UP) >> 24;
    return avrlg_pkg::LEVEL_W'(64'(avrlg_pkg::LVL_BLACK) - drop);
  endfunction

  // Level of the current byte, then advance the scan and name the next pixel
  function automatic level_beat_t predict_level(pixel_t px);
    level_beat_t e;
    int unsigned len;
    int unsigned row;
    int unsigned b;
    int unsigned ir;
    int unsigned ic;
    bit          hit;
    len = line_bytes();
    row = ras_row;
    b   = ras_byte;
    if (b >= len) b = len - 1;
    if (row >= TOTAL_ROWS) row = 0;
    e.level  = overlay_pixel(row, b, ir, ic) ? luma_level(px) : backdrop_level(row, b);
    e.fstart = (row == 0 && b == 0);
    if (b + 1 >= len) begin
      b   = 0;
      row = (row + 1 >= TOTAL_ROWS) ? 0 : row + 1;
    end else begin
      b = b + 1;
    end
    ras_byte = avrlg_pkg::BYTE_W'(b);
    ras_row  = avrlg_pkg::ROW_W'(row);
    hit       = overlay_pixel(row, b, ir, ic);
    e.in_img  = hit;
    e.img_row = hit ? avrlg_pkg::ROW_W'(ir) : '0;
    e.img_col = hit ? avrlg_pkg::COL_W'(ic) : '0;
    return e;
  endfunction

  // Track register writes and predict every accepted pixel beat
  always @(posedge clk) begin
    if (!rst_n) begin
      ras_cols   = avrlg_pkg::RESET_COLS;
      ras_img_w  = '0;
      ras_img_h  = '0;
      ras_off_x  = '0;
      ras_off_y  = '0;
      ras_mirror = 1'b0;
      ras_byte   = '0;
      ras_row    = '0;
      level_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          avrlg_pkg::CFG_COLUMNS: begin
            // A new line length restarts the frame
            ras_cols = cfg_wdata[avrlg_pkg::COL_W-1:0];
            ras_byte = '0;
            ras_row  = '0;
          end
          avrlg_pkg::CFG_WIDTH:    ras_img_w  = cfg_wdata[avrlg_pkg::COL_W-1:0];
          avrlg_pkg::CFG_HEIGHT:   ras_img_h  = cfg_wdata[avrlg_pkg::ROW_W-1:0];
          avrlg_pkg::CFG_OFFSET_X: ras_off_x  = cfg_wdata[avrlg_pkg::BYTE_W-1:0];
          avrlg_pkg::CFG_OFFSET_Y: ras_off_y  = cfg_wdata[avrlg_pkg::ROW_W-1:0];
          avrlg_pkg::CFG_MIRROR:   ras_mirror = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        beat_px = '{red: red, green: green, blue: blue};
        level_due_q.push_back(predict_level(beat_px));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: hold valid and payload until taken, then offer the next beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pixel_feed_q.size() != 0 && gap_odds != 0 &&
                   $urandom_range(0, 99) < gap_odds) begin
        // Idle burst of random length, this one included
        src_gap = $urandom_range(0, 16);
        in_valid <= 1'b0;
      end else if (pixel_feed_q.size() != 0) begin
        next_px = pixel_feed_q.pop_front();
        in_valid <= 1'b1;
        red      <= next_px.red;
        green    <= next_px.green;
        blue     <= next_px.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Level monitor: check each taken beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        got_beat = '{level: level, in_img: next_in_image, img_row: next_image_row,
                     img_col: next_image_col, fstart: frame_start};
        if (level_due_q.size() == 0) begin
          report_mismatch("beat with nothing pending", 0, 0);
        end else begin
          want_beat = level_due_q.pop_front();
          if (got_beat.level != want_beat.level)
            report_mismatch("level", got_beat.level, want_beat.level);
          if (got_beat.in_img != want_beat.in_img)
            report_mismatch("next_in_image", got_beat.in_img, want_beat.in_img);
          if (got_beat.img_row != want_beat.img_row)
            report_mismatch("next_image_row", got_beat.img_row, want_beat.img_row);
          if (got_beat.img_col != want_beat.img_col)
            report_mismatch("next_image_col", got_beat.img_col, want_beat.img_col);
          if (got_beat.fstart != want_beat.fstart)
            report_mismatch("frame_start", got_beat.fstart, want_beat.fstart);
        end
        // Back-pressure: hold off long enough for the block to fill and stall its input
        if (beats_out == HOLD_AT_BEAT) sink_hold = LONG_HOLD;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
        sink_hold = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Bias each channel toward its extremes now and then
  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'($urandom);
    if ($urandom_range(0, 3) == 0) p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 3) == 0) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 3) == 0) p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  task automatic queue_random(int unsigned n);
    repeat (n) pixel_feed_q.push_back(random_pixel());
  endtask

  task automatic write_reg(logic [avrlg_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Rewrite the overlay registers in mid frame, plus a write to an unused index
  task automatic set_overlay(cfg_word_t w, cfg_word_t h, cfg_word_t ox, cfg_word_t oy,
                             cfg_word_t mir);
    write_reg(avrlg_pkg::CFG_WIDTH, w);
    write_reg(avrlg_pkg::CFG_HEIGHT, h);
    write_reg(avrlg_pkg::CFG_OFFSET_X, ox);
    write_reg(avrlg_pkg::CFG_OFFSET_Y, oy);
    write_reg(avrlg_pkg::CFG_MIRROR, mir);
    write_reg(CFG_SPARE, avrlg_pkg::CFG_DATA_W'($urandom));
  endtask

  // Rewrite every register; the column write restarts the frame
  task automatic set_raster(cfg_word_t cols, cfg_word_t w, cfg_word_t h, cfg_word_t ox,
                            cfg_word_t oy, cfg_word_t mir);
    write_reg(avrlg_pkg::CFG_COLUMNS, cols);
    set_overlay(w, h, ox, oy, mir);
  endtask

  // Wait until every beat is taken and checked; sample between edges
  task automatic drain_raster();
    do @(negedge clk);
    while (pixel_feed_q.size() != 0 || in_valid || level_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: frame start, sync rows and the 512-column line, no bitmap
    gap_odds = 10;
    queue_random(24);
    drain_raster();

    // Column count 0 acts as 16; full-size bitmap clipped to the visible columns.
    // The first bytes of the first image row carry the color corners.
    set_raster(13'd0, 13'd4095, 13'd1023, 13'd0, 13'd0, 13'd0);
    gap_odds = 0;
    queue_random(23 * 32);
    for (int k = 0; k < 8; k++)
      pixel_feed_q.push_back('{red: k[0] ? 8'hFF : 8'h00, green: k[1] ? 8'hFF : 8'h00,
                               blue: k[2] ? 8'hFF : 8'h00});
    pixel_feed_q.push_back('{red: 8'h01, green: 8'h01, blue: 8'h01});
    pixel_feed_q.push_back('{red: 8'hFE, green: 8'hFE, blue: 8'hFE});
    pixel_feed_q.push_back('{red: 8'h80, green: 8'h00, blue: 8'h00});
    pixel_feed_q.push_back('{red: 8'h00, green: 8'h80, blue: 8'h00});
    pixel_feed_q.push_back('{red: 8'h00, green: 8'h00, blue: 8'h80});
    pixel_feed_q.push_back('{red: 8'h55, green: 8'hAA, blue: 8'h55});
    pixel_feed_q.push_back('{red: 8'hAA, green: 8'h55, blue: 8'hAA});
    pixel_feed_q.push_back('{red: 8'h01, green: 8'h00, blue: 8'h01});
    queue_random(16);
    drain_raster();

    // Small bitmap at an odd byte offset, two rows down; the long stall lands here
    set_overlay(13'd3, 13'd5, 13'd7, 13'd2, 13'd0);
    gap_odds = 25;
    queue_random(200);
    drain_raster();

    // Mirrored bitmap; the offsets are set high and must have no effect
    set_overlay(13'd9, 13'd20, 13'd8190, 13'd1023, 13'd1);
    gap_odds = 5;
    queue_random(150);
    drain_raster();

    // Bitmap columns cut at the line end
    set_overlay(13'd13, 13'd40, 13'd20, 13'd5, 13'd0);
    gap_odds = 3;
    queue_random(80);
    drain_raster();

    // Random placements in the same frame
    repeat (3) begin
      set_overlay(cfg_word_t'($urandom_range(0, 30)), cfg_word_t'($urandom_range(0, 40)),
                  cfg_word_t'($urandom_range(0, 40)), cfg_word_t'($urandom_range(0, 20)),
                  cfg_word_t'($urandom_range(0, 1)));
      gap_odds = 15;
      queue_random(60);
      drain_raster();
    end

    // Widest line, no idling on either side to finish.
    // The column value carries a bit above the register width.
    set_raster(13'h1FFF, 13'd4095, 13'd1023, 13'd0, 13'd0, 13'd0);
    gap_odds = 0;
    queue_random(100);
    drain_raster();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
